### hdl/cfcp_pkg.sv
// Shared types for the class file constant pool parser.
// Holds the result kind codes, the constant pool tag codes and the result record; no dependencies.
package cfcp_pkg;

  typedef enum logic [3:0] {
    KIND_MINOR     = 4'd0,
    KIND_MAJOR     = 4'd1,
    KIND_POOL_CNT  = 4'd2,
    KIND_TAG       = 4'd3,
    KIND_FIELD     = 4'd4,
    KIND_UTF8_BYTE = 4'd5,
    KIND_ACCESS    = 4'd6,
    KIND_BAD_MAGIC = 4'd7,
    KIND_BAD_TAG   = 4'd8
  } kind_e;

  localparam logic [7:0] TAG_UTF8       = 8'd1;
  localparam logic [7:0] TAG_INTEGER    = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IFACE_MREF = 8'd11;
  localparam logic [7:0] TAG_NAME_TYPE  = 8'd12;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] entry_index;
    logic [7:0]  entry_tag;
    logic [1:0]  field_number;
    logic [31:0] field_value;
    logic        entry_last;
  } res_t;

endpackage

### hdl/cfcp_if.sv
// Stream channel interfaces: byte input channel and parse result channel.
// Depends on cfcp_pkg for the result kind type.
interface cfcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface cfcp_out_if import cfcp_pkg::*;;
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [15:0] entry_index;
  logic [7:0]  entry_tag;
  logic [1:0]  field_number;
  logic [31:0] field_value;
  logic        entry_last;

  modport source (output valid, output kind, output entry_index, output entry_tag,
                  output field_number, output field_value, output entry_last,
                  input ready);
  modport sink   (input valid, input kind, input entry_index, input entry_tag,
                  input field_number, input field_value, input entry_last,
                  output ready);
endinterface

### hdl/class_file_constant_pool_parser_unit.sv
// Top level of the class file constant pool parser: input register, parser, result register.
// Depends on cfcp_pkg, cfcp_in_if/cfcp_out_if, cfcp_apb_regs and cfcp_parse.
//
//  channel | dir | transfer          | payload
//  in_i    | in  | valid & ready     | data_byte, start_req
//  out_o   | out | valid & ready     | kind, entry_index, entry_tag, field_number,
//          |     |                   | field_value, entry_last
//  apb     | in  | psel&penable&pwrite | expected magic at address 0
//
// One byte per cycle sustained while the result register is not stalled; each byte is
// held in the input register, and its result, if any, is then captured in the result register,
// which raises result valid; the result transfer can happen no earlier than that.
// Reset is asynchronous, active low; the magic register resets to 0xCAFEBABE.
// A stalled result register holds the input register, which then drops ready while it holds a byte.
module class_file_constant_pool_parser_unit import cfcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfcp_in_if.sink     in_i,
  cfcp_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        in_start_q;
  logic        res_v_q;
  res_t        res_q;
  logic        adv;
  logic        in_ready;
  logic        step;
  logic        res_valid;
  res_t        res;
  logic [31:0] magic;

  cfcp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .magic_o (magic)
  );

  assign adv      = !res_v_q || out_o.ready;
  assign in_ready = !in_v_q || adv;
  assign step     = in_v_q && adv;

  cfcp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .magic_i     (magic),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_q <= in_i.valid;
      end
      if (adv) begin
        res_v_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.start_req;
    end
    if (res_valid && adv) begin
      res_q <= res;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = res_v_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.entry_index  = res_q.entry_index;
  assign out_o.entry_tag    = res_q.entry_tag;
  assign out_o.field_number = res_q.field_number;
  assign out_o.field_value  = res_q.field_value;
  assign out_o.entry_last   = res_q.entry_last;

`ifndef SYNTHESIS
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_v_q && res_v_q))
    else $error("input stage stalled while empty");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_v_q || out_o.ready) && !in_v_q |=> !res_v_q)
    else $error("result produced without a byte");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_q.entry_last |->
      (res_q.kind == KIND_FIELD || res_q.kind == KIND_UTF8_BYTE))
    else $error("entry_last on a non-field result");

  a_utf8_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_q.kind == KIND_UTF8_BYTE |->
      (res_q.field_number == 2'd1 && res_q.field_value[31:8] == 24'd0))
    else $error("malformed utf8 byte result");
`endif

endmodule

### hdl/cfcp_apb_regs.sv
// APB configuration register file: holds the expected magic word.
// No package dependencies.
module cfcp_apb_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] magic_o
);

  localparam logic [0:0] AddrMagic = 1'b0;

  logic [31:0] magic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= 32'hCAFE_BABE;
    end else if (psel && penable && pwrite && pready && (paddr == AddrMagic)) begin
      magic_q <= pwdata;
    end
  end

  assign pready  = 1'b1;
  assign prdata  = (paddr == AddrMagic) ? magic_q : 32'd0;
  assign magic_o = magic_q;

endmodule

### hdl/cfcp_parse.sv
// Parse state machine: consumes one byte per step and forms at most one result.
// Depends on cfcp_pkg for kind_e, res_t and the tag codes.
module cfcp_parse import cfcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        start_i,
  input  logic [31:0] magic_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_MINOR, PH_MAJOR, PH_COUNT, PH_TAG,
    PH_FIELD, PH_UBYTES, PH_ACCESS, PH_DONE, PH_ERROR
  } phase_e;

  function automatic logic [1:0] field_total(input logic [7:0] tag);
    logic [1:0] n;
    case (tag)
      TAG_UTF8, TAG_INTEGER, TAG_FLOAT, TAG_CLASS, TAG_STRING: n = 2'd1;
      TAG_LONG, TAG_DOUBLE, TAG_FIELDREF, TAG_METHODREF, TAG_IFACE_MREF,
      TAG_NAME_TYPE: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  phase_e      ph_q, ph_d;
  logic [1:0]  bc_q, bc_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] pc_q, pc_d;
  logic [15:0] pi_q, pi_d;
  logic [7:0]  tag_q, tag_d;
  logic [1:0]  fs_q, fs_d;
  logic [15:0] ur_q, ur_d;

  always_comb begin
    phase_e      ph;
    logic [1:0]  bc;
    logic [31:0] acc;
    logic [15:0] pc;
    logic [15:0] pi;
    logic [7:0]  tag;
    logic [1:0]  fs;
    logic [15:0] ur;
    logic [31:0] acc_sh;
    logic        wide;
    logic        done;
    logic [31:0] fval;
    logic [16:0] nxt;
    phase_e      ne_ph;
    logic [15:0] ne_pi;
    logic        last;
    logic [15:0] ur_m;

    ph  = start_i ? PH_MAGIC : ph_q;
    bc  = start_i ? 2'd0 : bc_q;
    acc = start_i ? 32'd0 : acc_q;
    pc  = start_i ? 16'd0 : pc_q;
    pi  = start_i ? 16'd1 : pi_q;
    tag = start_i ? 8'd0 : tag_q;
    fs  = start_i ? 2'd0 : fs_q;
    ur  = start_i ? 16'd0 : ur_q;

    acc_sh = {acc[23:0], byte_i};
    wide   = (tag >= TAG_INTEGER) && (tag <= TAG_DOUBLE);
    done   = wide ? (bc == 2'd3) : (bc == 2'd1);
    fval   = wide ? acc_sh : {16'd0, acc_sh[15:0]};
    nxt    = {1'b0, pi} + (((tag == TAG_LONG) || (tag == TAG_DOUBLE)) ? 17'd2 : 17'd1);
    ne_ph  = (nxt >= {1'b0, pc}) ? PH_ACCESS : PH_TAG;
    ne_pi  = (nxt >= {1'b0, pc}) ? pi : nxt[15:0];
    ur_m   = ur - 16'd1;
    last   = 1'b0;

    ph_d  = ph;
    bc_d  = bc;
    acc_d = acc;
    pc_d  = pc;
    pi_d  = pi;
    tag_d = tag;
    fs_d  = fs;
    ur_d  = ur;

    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_MINOR;

    case (ph)
      PH_MAGIC: begin
        if (bc == 2'd3) begin
          bc_d  = 2'd0;
          acc_d = 32'd0;
          if (acc_sh != magic_i) begin
            ph_d              = PH_ERROR;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_BAD_MAGIC;
            res_o.field_value = acc_sh;
          end else begin
            ph_d = PH_MINOR;
          end
        end else begin
          bc_d  = bc + 2'd1;
          acc_d = acc_sh;
        end
      end
      PH_MINOR, PH_MAJOR, PH_COUNT, PH_ACCESS: begin
        if (bc == 2'd1) begin
          bc_d              = 2'd0;
          acc_d             = 32'd0;
          res_valid_o       = 1'b1;
          res_o.field_value = {16'd0, acc_sh[15:0]};
          case (ph)
            PH_MINOR: begin
              ph_d       = PH_MAJOR;
              res_o.kind = KIND_MINOR;
            end
            PH_MAJOR: begin
              ph_d       = PH_COUNT;
              res_o.kind = KIND_MAJOR;
            end
            PH_COUNT: begin
              pc_d       = acc_sh[15:0];
              pi_d       = 16'd1;
              ph_d       = (acc_sh[15:0] <= 16'd1) ? PH_ACCESS : PH_TAG;
              res_o.kind = KIND_POOL_CNT;
            end
            default: begin
              ph_d       = PH_DONE;
              res_o.kind = KIND_ACCESS;
            end
          endcase
        end else begin
          bc_d  = bc + 2'd1;
          acc_d = acc_sh;
        end
      end
      PH_TAG: begin
        tag_d             = byte_i;
        res_valid_o       = 1'b1;
        res_o.entry_index = pi;
        res_o.entry_tag   = byte_i;
        res_o.field_value = {24'd0, byte_i};
        if (field_total(byte_i) == 2'd0) begin
          ph_d       = PH_ERROR;
          res_o.kind = KIND_BAD_TAG;
        end else begin
          fs_d       = 2'd0;
          bc_d       = 2'd0;
          acc_d      = 32'd0;
          ph_d       = PH_FIELD;
          res_o.kind = KIND_TAG;
        end
      end
      PH_FIELD: begin
        if (done) begin
          bc_d  = 2'd0;
          acc_d = 32'd0;
          if (tag == TAG_UTF8) begin
            ur_d = fval[15:0];
            last = (fval[15:0] == 16'd0);
          end else begin
            last = (({1'b0, fs} + 3'd1) >= {1'b0, field_total(tag)});
          end
          if (last) begin
            ph_d = ne_ph;
            pi_d = ne_pi;
            fs_d = 2'd0;
          end else if (tag == TAG_UTF8) begin
            ph_d = PH_UBYTES;
          end else begin
            fs_d = fs + 2'd1;
          end
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_FIELD;
          res_o.entry_index  = pi;
          res_o.entry_tag    = tag;
          res_o.field_number = fs;
          res_o.field_value  = fval;
          res_o.entry_last   = last;
        end else begin
          bc_d  = bc + 2'd1;
          acc_d = acc_sh;
        end
      end
      PH_UBYTES: begin
        ur_d = ur_m;
        last = (ur_m == 16'd0);
        if (last) begin
          ph_d  = ne_ph;
          pi_d  = ne_pi;
          fs_d  = 2'd0;
          bc_d  = 2'd0;
          acc_d = 32'd0;
        end
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_UTF8_BYTE;
        res_o.entry_index  = pi;
        res_o.entry_tag    = tag;
        res_o.field_number = 2'd1;
        res_o.field_value  = {24'd0, byte_i};
        res_o.entry_last   = last;
      end
      default: begin
      end
    endcase

    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_MAGIC;
      bc_q  <= 2'd0;
      acc_q <= 32'd0;
      pc_q  <= 16'd0;
      pi_q  <= 16'd1;
      tag_q <= 8'd0;
      fs_q  <= 2'd0;
      ur_q  <= 16'd0;
    end else if (step_i) begin
      ph_q  <= ph_d;
      bc_q  <= bc_d;
      acc_q <= acc_d;
      pc_q  <= pc_d;
      pi_q  <= pi_d;
      tag_q <= tag_d;
      fs_q  <= fs_d;
      ur_q  <= ur_d;
    end
  end

endmodule
